// ===== rtl/core/balu_pkg.sv =====
// ----------------------------------------------------------------------------
// balu_pkg: shared constants for the bit-serial integer ALU
// Opcode values and the default operand width.
// ----------------------------------------------------------------------------
package balu_pkg;

	localparam int DATA_WIDTH_DEF = 32;

	localparam int OP_W = 3;

	localparam logic [OP_W-1:0] OP_ADD = 3'd0;
	localparam logic [OP_W-1:0] OP_SUB = 3'd1;
	localparam logic [OP_W-1:0] OP_MUL = 3'd2;
	localparam logic [OP_W-1:0] OP_DIV = 3'd3;
	localparam logic [OP_W-1:0] OP_POW = 3'd4;

endpackage

// ===== rtl/core/balu_serial_add.sv =====
// ----------------------------------------------------------------------------
// balu_serial_add: bit-serial adder / subtractor
// One sum bit per cycle, LSB first, through a single carry flop.
// ----------------------------------------------------------------------------
module balu_serial_add #(
	parameter int DATA_WIDTH = balu_pkg::DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  sub,
	input  logic [DATA_WIDTH-1:0] x,
	input  logic [DATA_WIDTH-1:0] y,
	output logic                  done,
	output logic [DATA_WIDTH-1:0] sum
);

	localparam int CW = $clog2(DATA_WIDTH);

	logic [DATA_WIDTH-1:0] a_q, b_q, sum_q;
	logic                  c_q;
	logic [CW-1:0]         cnt_q;
	logic                  run_q, done_q;
	logic                  s_bit, c_next;

	assign s_bit  = a_q[0] ^ b_q[0] ^ c_q;
	assign c_next = (a_q[0] & b_q[0]) | (c_q & (a_q[0] ^ b_q[0]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(DATA_WIDTH - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= x;
			b_q <= sub ? ~y : y;
			c_q <= sub;
		end else if (run_q) begin
			a_q   <= {1'b0, a_q[DATA_WIDTH-1:1]};
			b_q   <= {1'b0, b_q[DATA_WIDTH-1:1]};
			c_q   <= c_next;
			sum_q <= {s_bit, sum_q[DATA_WIDTH-1:1]};
		end
	end

	assign done = done_q;
	assign sum  = sum_q;

endmodule

// ===== rtl/core/balu_mul.sv =====
// ----------------------------------------------------------------------------
// balu_mul: shift-add multiplier
// One multiplier bit per cycle; keeps the low DATA_WIDTH product bits.
// ----------------------------------------------------------------------------
module balu_mul #(
	parameter int DATA_WIDTH = balu_pkg::DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DATA_WIDTH-1:0] x,
	input  logic [DATA_WIDTH-1:0] y,
	output logic                  done,
	output logic [DATA_WIDTH-1:0] prod
);

	localparam int CW = $clog2(DATA_WIDTH);

	logic [DATA_WIDTH-1:0] acc_q, mc_q, mp_q;
	logic [CW-1:0]         cnt_q;
	logic                  run_q, done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(DATA_WIDTH - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			mc_q  <= x;
			mp_q  <= y;
		end else if (run_q) begin
			if (mp_q[0]) begin
				acc_q <= acc_q + mc_q;
			end
			mc_q <= {mc_q[DATA_WIDTH-2:0], 1'b0};
			mp_q <= {1'b0, mp_q[DATA_WIDTH-1:1]};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

// ===== rtl/core/balu_div.sv =====
// ----------------------------------------------------------------------------
// balu_div: restoring signed divider
// One quotient bit per cycle on magnitudes; quotient truncates toward zero.
// ----------------------------------------------------------------------------
module balu_div #(
	parameter int DATA_WIDTH = balu_pkg::DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DATA_WIDTH-1:0] x,
	input  logic [DATA_WIDTH-1:0] y,
	output logic                  done,
	output logic [DATA_WIDTH-1:0] quot
);

	localparam int CW = $clog2(DATA_WIDTH);

	logic [DATA_WIDTH-1:0] dvd_q, dvs_q, rem_q;
	logic                  neg_q;
	logic [CW-1:0]         cnt_q;
	logic                  run_q, done_q;
	logic [DATA_WIDTH:0]   rem_sh, diff;
	logic                  q_bit;

	assign rem_sh = {rem_q, dvd_q[DATA_WIDTH-1]};
	assign diff   = rem_sh - {1'b0, dvs_q};
	assign q_bit  = ~diff[DATA_WIDTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(DATA_WIDTH - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= x[DATA_WIDTH-1] ? (~x + 1'b1) : x;
			dvs_q <= y[DATA_WIDTH-1] ? (~y + 1'b1) : y;
			neg_q <= x[DATA_WIDTH-1] ^ y[DATA_WIDTH-1];
			rem_q <= '0;
		end else if (run_q) begin
			// quotient bits shift in where the dividend bits leave
			rem_q <= q_bit ? diff[DATA_WIDTH-1:0] : rem_sh[DATA_WIDTH-1:0];
			dvd_q <= {dvd_q[DATA_WIDTH-2:0], q_bit};
		end
	end

	assign done = done_q;
	assign quot = neg_q ? (~dvd_q + 1'b1) : dvd_q;

endmodule

// ===== rtl/core/bitwise_integer_alu.sv =====
// ----------------------------------------------------------------------------
// bitwise_integer_alu: multicycle integer ALU
// Add, subtract, multiply, divide and power on signed operands, one bit of
// work per cycle in each arithmetic unit.
// ----------------------------------------------------------------------------
// A command transfers at a clock edge with start high and busy low. The block
// then holds busy high until it has shown the result: result and
// divide_by_zero are valid for exactly one cycle while done is high, and the
// receiver cannot stall them, so it must take them in that cycle. busy drops
// in the cycle after done. The time that add, subtract, multiply and divide
// take is set by the one-bit-per-cycle serial adder, shift-add multiplier and
// restoring divider. Power runs on the single shared multiplier: each
// exponent bit costs one inspection and one squaring, plus one extra multiply
// when the bit is set. Divide by zero, power with an exponent of zero or
// below, and unused opcodes go straight to the done state. All results wrap
// modulo 2^DATA_WIDTH; a divide by zero gives 0 with divide_by_zero set.
// ----------------------------------------------------------------------------
module bitwise_integer_alu #(
	parameter int DATA_WIDTH = balu_pkg::DATA_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [balu_pkg::OP_W-1:0]     opcode,
	input  logic signed [DATA_WIDTH-1:0]  operand_a,
	input  logic signed [DATA_WIDTH-1:0]  operand_b,
	output logic                          done,
	output logic signed [DATA_WIDTH-1:0]  result,
	output logic                          divide_by_zero
);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_ADD  = 8'b0000_0010,
		S_MUL  = 8'b0000_0100,
		S_DIV  = 8'b0000_1000,
		S_PEXP = 8'b0001_0000,  // power: inspect next exponent bit
		S_PACC = 8'b0010_0000,  // power: acc * sq running
		S_PSQ  = 8'b0100_0000,  // power: sq * sq running
		S_DONE = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [DATA_WIDTH-1:0] res_q;
	logic                  dz_q;
	logic [DATA_WIDTH-1:0] acc_q, sq_q, exp_q;

	// unit hookups
	logic                  add_start, add_done;
	logic                  add_sub;
	logic [DATA_WIDTH-1:0] add_sum;
	logic                  mul_start, mul_done;
	logic [DATA_WIDTH-1:0] mul_x, mul_y, mul_prod;
	logic                  div_start, div_done;
	logic [DATA_WIDTH-1:0] div_quot;
	logic                  accept;

	assign accept = start && (state_q == S_IDLE);

	assign add_start = accept && (opcode inside {balu_pkg::OP_ADD, balu_pkg::OP_SUB});
	assign add_sub   = (opcode == balu_pkg::OP_SUB);
	assign div_start = accept && (opcode == balu_pkg::OP_DIV) && (operand_b != '0);

	// Multiplier is shared between the plain multiply and the power loop.
	always_comb begin
		mul_start = 1'b0;
		mul_x     = sq_q;
		mul_y     = sq_q;
		case (state_q)
			S_IDLE: begin
				mul_start = accept && (opcode == balu_pkg::OP_MUL);
				mul_x     = operand_a;
				mul_y     = operand_b;
			end
			S_PEXP: begin
				mul_start = (exp_q != '0);
				if (exp_q[0]) begin
					mul_x = acc_q;
				end
			end
			S_PACC: begin
				mul_start = mul_done;
			end
			default: begin
			end
		endcase
	end

	balu_serial_add #(.DATA_WIDTH(DATA_WIDTH)) u_add (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (add_start),
		.sub    (add_sub),
		.x      (operand_a),
		.y      (operand_b),
		.done   (add_done),
		.sum    (add_sum)
	);

	balu_mul #(.DATA_WIDTH(DATA_WIDTH)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.x      (mul_x),
		.y      (mul_y),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	balu_div #(.DATA_WIDTH(DATA_WIDTH)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.x      (operand_a),
		.y      (operand_b),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (opcode)
							balu_pkg::OP_ADD, balu_pkg::OP_SUB: state_q <= S_ADD;
							balu_pkg::OP_MUL:                   state_q <= S_MUL;
							balu_pkg::OP_DIV: begin
								state_q <= (operand_b == '0) ? S_DONE : S_DIV;
							end
							balu_pkg::OP_POW: begin
								// exponent of zero or below short-cuts to 1
								if (operand_b[DATA_WIDTH-1] || operand_b == '0) begin
									state_q <= S_DONE;
								end else begin
									state_q <= S_PEXP;
								end
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_ADD: begin
					if (add_done) state_q <= S_DONE;
				end
				S_MUL: begin
					if (mul_done) state_q <= S_DONE;
				end
				S_DIV: begin
					if (div_done) state_q <= S_DONE;
				end
				S_PEXP: begin
					if (exp_q == '0) begin
						state_q <= S_DONE;
					end else if (exp_q[0]) begin
						state_q <= S_PACC;
					end else begin
						state_q <= S_PSQ;
					end
				end
				S_PACC: begin
					if (mul_done) state_q <= S_PSQ;
				end
				S_PSQ: begin
					if (mul_done) state_q <= S_PEXP;
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					res_q <= '0;
					dz_q  <= 1'b0;
					acc_q <= DATA_WIDTH'(1);
					sq_q  <= operand_a;
					exp_q <= operand_b;
					if (opcode == balu_pkg::OP_DIV && operand_b == '0) begin
						dz_q <= 1'b1;
					end
					if (opcode == balu_pkg::OP_POW) begin
						res_q <= DATA_WIDTH'(1);
					end
				end
			end
			S_ADD: begin
				if (add_done) res_q <= add_sum;
			end
			S_MUL: begin
				if (mul_done) res_q <= mul_prod;
			end
			S_DIV: begin
				if (div_done) res_q <= div_quot;
			end
			S_PEXP: begin
				if (exp_q == '0) res_q <= acc_q;
			end
			S_PACC: begin
				if (mul_done) acc_q <= mul_prod;
			end
			S_PSQ: begin
				if (mul_done) begin
					sq_q  <= mul_prod;
					exp_q <= {1'b0, exp_q[DATA_WIDTH-1:1]};
				end
			end
			default: begin
			end
		endcase
	end

	assign busy           = (state_q != S_IDLE);
	assign done           = (state_q == S_DONE);
	assign result         = res_q;
	assign divide_by_zero = dz_q;

endmodule

// ===== bench/bitwise_integer_alu_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitwise_integer_alu_tb: self-checking bench for the multicycle integer ALU
// Directed corner cases per opcode, then random commands with random sender
// gaps, a gap-free burst and a full drain. Each result is checked against
// an in-bench model of the ALU.
// ----------------------------------------------------------------------------
module bitwise_integer_alu_tb;

	localparam int W           = balu_pkg::DATA_WIDTH_DEF;
	localparam int STALL_LIMIT = 12000;
	localparam int TAIL_CYCLES = W + 8;	// settle time after the last result
	localparam int MAX_REPORTS = 10;

	// opcodes the block must answer with a plain zero
	localparam logic [balu_pkg::OP_W-1:0] OP_UNUSED_LO = 3'd5;
	localparam logic [balu_pkg::OP_W-1:0] OP_UNUSED_HI = 3'd7;

	localparam logic signed [W-1:0] MAX_S = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] MIN_S = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [W-1:0] NEG_1 = '1;

	typedef struct packed {
		logic [W-1:0] value;
		logic         div_zero;
	} alu_outcome_t;

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic [balu_pkg::OP_W-1:0]     opcode;
	logic signed [W-1:0]           operand_a;
	logic signed [W-1:0]           operand_b;
	logic                          done;
	logic signed [W-1:0]           result;
	logic                          divide_by_zero;

	alu_outcome_t pending_results[$];
	int           mismatch_count;
	int           quiet_cycles;
	bit           gaps_on;

	bitwise_integer_alu #(.DATA_WIDTH(W)) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.opcode         (opcode),
		.operand_a      (operand_a),
		.operand_b      (operand_b),
		.done           (done),
		.result         (result),
		.divide_by_zero (divide_by_zero)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// ------------------------------------------------------------------------
	// ALU model: everything wraps modulo 2^W, so unsigned W-bit arithmetic
	// gives the right low bits for add, subtract, multiply and power.
	// ------------------------------------------------------------------------
	function automatic alu_outcome_t alu_compute(logic [balu_pkg::OP_W-1:0] op,
			logic [W-1:0] a, logic [W-1:0] b);
		alu_outcome_t o;
		logic [W-1:0] mag_a, mag_b, acc, sq, e;
		o.value    = '0;
		o.div_zero = 1'b0;
		case (op)
			balu_pkg::OP_ADD: o.value = a + b;
			balu_pkg::OP_SUB: o.value = a - b;
			balu_pkg::OP_MUL: o.value = a * b;
			balu_pkg::OP_DIV: begin
				if (b == '0) begin
					o.div_zero = 1'b1;
				end else begin
					// truncate toward zero: divide magnitudes, then fix sign;
					// the most negative value keeps its bits as a magnitude
					mag_a = a[W-1] ? (~a + 1'b1) : a;
					mag_b = b[W-1] ? (~b + 1'b1) : b;
					o.value = mag_a / mag_b;
					if (a[W-1] ^ b[W-1])
						o.value = ~o.value + 1'b1;
				end
			end
			balu_pkg::OP_POW: begin
				// exponent zero or negative gives 1
				acc = W'(1);
				if (!b[W-1]) begin
					sq = a;
					e  = b;
					while (e != '0) begin
						if (e[0])
							acc = acc * sq;
						sq = sq * sq;
						e  = e >> 1;
					end
				end
				o.value = acc;
			end
			default: o.value = '0;
		endcase
		return o;
	endfunction

	// ------------------------------------------------------------------------
	// Result checker: done marks a one-cycle result that the bench must take
	// at the closing edge. Values read here are the pre-edge ones.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		alu_outcome_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("%0t: unexpected result %0d dz=%0b", $realtime,
						result, divide_by_zero);
			end else begin
				want = pending_results.pop_front();
				if (result !== want.value || divide_by_zero !== want.div_zero) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("%0t: result exp %0d (0x%h) dz=%0b, got %0d (0x%h) dz=%0b",
							$realtime, $signed(want.value), want.value, want.div_zero,
							result, result, divide_by_zero);
				end
			end
		end
	end

	// Watchdog: counts cycles with neither a command transfer nor a result.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("bitwise_integer_alu: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------------
	// Sender. Called just after a rising edge. start stays high across
	// back-to-back commands; it only drops for a gap or a drain.
	// ------------------------------------------------------------------------
	task automatic send_cmd(logic [balu_pkg::OP_W-1:0] op, logic [W-1:0] a,
			logic [W-1:0] b);
		int gap;
		gap = 0;
		if (gaps_on)
			while ($urandom_range(99) < 37)
				gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start     <= 1'b1;
		opcode    <= op;
		operand_a <= a;
		operand_b <= b;
		// transfer happens at the first edge that sees busy low
		do @(posedge clk); while (busy);
		pending_results.push_back(alu_compute(op, a, b));
	endtask

	// Drop start and hold off until every issued command has answered.
	task automatic wait_drained();
		start <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// Corners, a few small values, otherwise full-range random.
	function automatic logic [W-1:0] pick_operand();
		logic [W-1:0] v;
		v = W'({$urandom, $urandom});
		case ($urandom_range(9))
			0: v = '0;
			1: v = 1;
			2: v = NEG_1;
			3: v = MAX_S;
			4: v = MIN_S;
			5, 6: begin
				v = $urandom_range(31);
				if ($urandom_range(1))
					v = ~v + 1'b1;
			end
			default: ;
		endcase
		return v;
	endfunction

	task automatic send_random();
		logic [balu_pkg::OP_W-1:0] op;
		logic [W-1:0]              a, b;
		int                        pick;
		pick = $urandom_range(99);
		if (pick < 18)
			op = balu_pkg::OP_ADD;
		else if (pick < 36)
			op = balu_pkg::OP_SUB;
		else if (pick < 54)
			op = balu_pkg::OP_MUL;
		else if (pick < 72)
			op = balu_pkg::OP_DIV;
		else if (pick < 90)
			op = balu_pkg::OP_POW;
		else
			op = balu_pkg::OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
		a = pick_operand();
		b = pick_operand();
		if (op == balu_pkg::OP_DIV && $urandom_range(9) == 0)
			b = '0;
		if (op == balu_pkg::OP_POW) begin
			// mostly short exponents; long ones are the slowest
			pick = $urandom_range(99);
			if (pick < 15)
				b = (pick < 5) ? '0 : (b | MIN_S);
			else if (pick < 80)
				b = $urandom_range(1, 40);
			else
				b = b & MAX_S;
		end
		send_cmd(op, a, b);
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	task automatic test_add_sub_mul_corners();
		send_cmd(balu_pkg::OP_ADD, MAX_S, 1);		// overflow wraps to most negative
		send_cmd(balu_pkg::OP_ADD, MIN_S, MIN_S);
		send_cmd(balu_pkg::OP_ADD, NEG_1, 1);
		send_cmd(balu_pkg::OP_SUB, MIN_S, 1);		// wraps to most positive
		send_cmd(balu_pkg::OP_SUB, '0, MIN_S);
		send_cmd(balu_pkg::OP_MUL, MIN_S, NEG_1);
		send_cmd(balu_pkg::OP_MUL, MAX_S, MAX_S);
		send_cmd(balu_pkg::OP_MUL, 32'h0001_0000, 32'h0001_0000);
	endtask

	task automatic test_divide_corners();
		send_cmd(balu_pkg::OP_DIV, 100, '0);		// divide by zero flags the error
		send_cmd(balu_pkg::OP_DIV, MIN_S, NEG_1);	// quotient overflows to most negative
		send_cmd(balu_pkg::OP_DIV, -7, 2);		// truncation toward zero
		send_cmd(balu_pkg::OP_DIV, 7, -2);
		send_cmd(balu_pkg::OP_DIV, MIN_S, MIN_S);
		send_cmd(balu_pkg::OP_DIV, 5, 7);
		send_cmd(balu_pkg::OP_DIV, MAX_S, 1);
	endtask

	task automatic test_power_corners();
		send_cmd(balu_pkg::OP_POW, 2, W - 1);		// lands on the sign bit
		send_cmd(balu_pkg::OP_POW, 2, W);		// wraps to zero
		send_cmd(balu_pkg::OP_POW, 3, '0);		// zero exponent
		send_cmd(balu_pkg::OP_POW, 5, -3);		// negative exponent
		send_cmd(balu_pkg::OP_POW, NEG_1, MAX_S);	// longest exponent
		send_cmd(balu_pkg::OP_POW, -3, 5);
		send_cmd(balu_pkg::OP_POW, 7, MAX_S);
		send_cmd(balu_pkg::OP_POW, MIN_S, 1);
	endtask

	task automatic test_unused_opcodes();
		logic [balu_pkg::OP_W-1:0] op;
		for (op = OP_UNUSED_LO; op <= OP_UNUSED_HI && op >= OP_UNUSED_LO; op++)
			send_cmd(op, W'({$urandom, $urandom}), W'({$urandom, $urandom}));
	endtask

	task automatic test_random_gapped(int count);
		gaps_on = 1'b1;
		repeat (count) send_random();
	endtask

	// back-to-back commands, no sender gaps at all
	task automatic test_random_burst(int count);
		gaps_on = 1'b0;
		repeat (count) send_random();
		gaps_on = 1'b1;
	endtask

	initial begin
		mismatch_count = 0;
		gaps_on        = 1'b1;
		arst_n    <= 1'b0;
		start     <= 1'b0;
		opcode    <= balu_pkg::OP_ADD;
		operand_a <= '0;
		operand_b <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_add_sub_mul_corners();
		test_divide_corners();
		test_power_corners();
		test_unused_opcodes();
		wait_drained();
		test_random_gapped(130);
		test_random_burst(64);
		wait_drained();
		test_random_gapped(70);
		wait_drained();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("bitwise_integer_alu: match");
		else
			$display("bitwise_integer_alu: mismatch");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/balu_pkg.sv
rtl/core/balu_serial_add.sv
rtl/core/balu_mul.sv
rtl/core/balu_div.sv
rtl/core/bitwise_integer_alu.sv
bench/bitwise_integer_alu_tb.sv
